### rtl/vic_pkg.sv
// ============================================================================
// vic_pkg
// Shared types and constants of the vectored interrupt controller.
// ============================================================================
package vic_pkg;

    localparam int NUM_LINES = 32;
    localparam int CFG_DEPTH = 32;
    localparam int CFG_W     = 13;
    localparam int CFG_AW    = $clog2(CFG_DEPTH);
    localparam int WORD_W    = 6;
    localparam int MODE_W    = 4;

    localparam logic [31:0] LINE_MASK = 32'hFFFF_FFFF >> (32 - NUM_LINES);
    localparam logic [31:0] STATUS_FLAG = 32'h8000_0000;

    // Word indexes of the register map above the line configuration words.
    localparam logic [WORD_W-1:0] W_ENABLE     = 6'd32;
    localparam logic [WORD_W-1:0] W_ENABLE_SET = 6'd33;
    localparam logic [WORD_W-1:0] W_ENABLE_CLR = 6'd34;
    localparam logic [WORD_W-1:0] W_PENDING    = 6'd35;
    localparam logic [WORD_W-1:0] W_RAW        = 6'd36;
    localparam logic [WORD_W-1:0] W_SOFT       = 6'd37;
    localparam logic [WORD_W-1:0] W_SOFT_SET   = 6'd38;
    localparam logic [WORD_W-1:0] W_SOFT_CLR   = 6'd39;
    localparam logic [WORD_W-1:0] W_MODE       = 6'd40;
    localparam logic [WORD_W-1:0] W_STATUS     = 6'd41;
    localparam logic [WORD_W-1:0] W_BASE       = 6'd42;
    localparam logic [WORD_W-1:0] W_VECTOR     = 6'd43;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_LINE  = 2'd2
    } t_req_e;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] word;
        logic [31:0]       write_data;
        logic [4:0]        irq_line;
        logic              irq_level;
    } t_req;

endpackage

### rtl/vic_ram.sv
// ============================================================================
// vic_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module vic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/vic_regs.sv
// ============================================================================
// vic_regs
// Mask, line, software and vector registers with their read mux.
// ============================================================================
module vic_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  vic_pkg::t_req i_req,
    output logic [31:0]   o_rd_word,
    output logic          o_irq_next
);
    import vic_pkg::*;

    logic [31:0]       r_enable, n_enable;
    logic [31:0]       r_raw, n_raw;
    logic [31:0]       r_soft, n_soft;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [31:0]       r_base, n_base;

    logic [31:0] pending;
    logic [4:0]  win;
    logic        any;
    logic [31:0] status_word;
    logic [31:0] vector_word;
    logic [3:0]  shamt;
    logic        line_ok;

    assign pending = (r_raw | r_soft) & r_enable & LINE_MASK;

    // Lowest set bit wins: the last assignment in the loop is the lowest index.
    always_comb begin
        win = '0;
        for (int i = 31; i >= 0; i--) begin
            if (pending[i]) begin
                win = 5'(i);
            end
        end
    end

    assign any         = |pending;
    assign shamt       = 4'd2 + {1'b0, r_mode[2:0]};
    assign status_word = any ? (STATUS_FLAG | 32'(win)) : '0;
    assign vector_word = any ? (r_base + (32'(win) << shamt)) : '0;

    always_comb begin
        o_rd_word = '0;
        if (i_req.req_type == REQ_READ) begin
            unique case (i_req.word)
                W_ENABLE:  o_rd_word = r_enable;
                W_PENDING: o_rd_word = pending;
                W_RAW:     o_rd_word = r_raw;
                W_SOFT:    o_rd_word = r_soft;
                W_MODE:    o_rd_word = 32'(r_mode);
                W_STATUS:  o_rd_word = status_word;
                W_BASE:    o_rd_word = r_base;
                W_VECTOR:  o_rd_word = vector_word;
                default:   o_rd_word = '0;
            endcase
        end
    end

    assign line_ok = {1'b0, i_req.irq_line} < 6'(NUM_LINES);

    always_comb begin
        n_enable = r_enable;
        n_raw    = r_raw;
        n_soft   = r_soft;
        n_mode   = r_mode;
        n_base   = r_base;
        if (i_accept) begin
            unique case (i_req.req_type)
                REQ_WRITE: begin
                    unique case (i_req.word)
                        W_ENABLE:     n_enable = i_req.write_data;
                        W_ENABLE_SET: n_enable = r_enable | i_req.write_data;
                        W_ENABLE_CLR: n_enable = r_enable & ~i_req.write_data;
                        W_SOFT:       n_soft   = i_req.write_data;
                        W_SOFT_SET:   n_soft   = r_soft | i_req.write_data;
                        W_SOFT_CLR:   n_soft   = r_soft & ~i_req.write_data;
                        W_MODE:       n_mode   = i_req.write_data[MODE_W-1:0];
                        W_BASE:       n_base   = i_req.write_data;
                        default:      ;
                    endcase
                end
                REQ_LINE: begin
                    if (line_ok) begin
                        n_raw[i_req.irq_line] = i_req.irq_level;
                    end
                end
                default: ;
            endcase
        end
    end

    // Interrupt output as it stands once this transfer has taken effect.
    assign o_irq_next = |((n_raw | n_soft) & n_enable & LINE_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_raw    <= '0;
            r_soft   <= '0;
            r_mode   <= '0;
            r_base   <= '0;
        end else begin
            r_enable <= n_enable;
            r_raw    <= n_raw;
            r_soft   <= n_soft;
            r_mode   <= n_mode;
            r_base   <= n_base;
        end
    end

endmodule

### rtl/vectored_interrupt_controller.sv
// One transfer per cycle is taken unless the master side stalls; a result passes
// through stage one and the output register. The line configuration RAM takes one read
// and one write each cycle, and the result register frees the input side.
// Reset (synchronous, active low) clears the state registers, the pipeline valid flags
// and the per-entry valid bits, so unwritten line configuration words read as zero
// without a clearing pass.
// ============================================================================
// vectored_interrupt_controller
// 32-line vectored interrupt controller with a stream request/response port.
// ============================================================================
module vectored_interrupt_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] bus_addr, [39:8] write_data, [44:40] irq_line, [45] irq_level
    input  logic [47:0] i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] read_data, [32] irq_out
    output logic [39:0] o_m_tdata
);
    import vic_pkg::*;

    t_req        req;
    logic        accept;
    logic        cfg_word;
    logic        cfg_we;
    logic [CFG_W-1:0] ram_rdata;
    logic [31:0] regs_rd;
    logic        irq_next;

    logic [CFG_DEPTH-1:0] r_cfg_vld;
    logic        r_s1_vld;
    logic        r_s1_cfg_rd;
    logic        r_s1_entry_vld;
    logic [31:0] r_s1_rd;
    logic        r_s1_irq;
    logic        r_m_vld;
    logic [31:0] r_m_data;
    logic        r_m_irq;

    logic        out_free;
    logic        s1_move;
    logic [31:0] s1_data;

    assign req.req_type   = i_s_tuser;
    assign req.word       = i_s_tdata[7:2];
    assign req.write_data = i_s_tdata[39:8];
    assign req.irq_line   = i_s_tdata[44:40];
    assign req.irq_level  = i_s_tdata[45];

    assign out_free   = !r_m_vld || i_m_tready;
    assign s1_move    = r_s1_vld && out_free;
    assign o_s_tready = !r_s1_vld || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign cfg_word = !req.word[WORD_W-1];
    assign cfg_we   = accept && (req.req_type == REQ_WRITE) && cfg_word;

    vic_ram #(
        .WIDTH (CFG_W),
        .DEPTH (CFG_DEPTH)
    ) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (cfg_we),
        .i_waddr (req.word[CFG_AW-1:0]),
        .i_wdata (req.write_data[CFG_W-1:0]),
        .i_re    (accept),
        .i_raddr (req.word[CFG_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    vic_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (req),
        .o_rd_word  (regs_rd),
        .o_irq_next (irq_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_vld <= '0;
        end else if (cfg_we) begin
            r_cfg_vld[req.word[CFG_AW-1:0]] <= 1'b1;
        end
    end

    // Stage one waits for the RAM read; the RAM output holds while it stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cfg_rd    <= (req.req_type == REQ_READ) && cfg_word;
            r_s1_entry_vld <= r_cfg_vld[req.word[CFG_AW-1:0]];
            r_s1_rd        <= regs_rd;
            r_s1_irq       <= irq_next;
        end
    end

    assign s1_data = r_s1_cfg_rd ? (r_s1_entry_vld ? 32'(ram_rdata) : '0) : r_s1_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (s1_move) begin
            r_m_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_m_data <= s1_data;
            r_m_irq  <= r_s1_irq;
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = {7'd0, r_m_irq, r_m_data};

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted transfer did not reach stage one");

    // Only a read of a written entry carries defined RAM data worth checking.
    a_stall_holds_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_free) |=>
            (r_s1_vld && (!(r_s1_cfg_rd && r_s1_entry_vld) || $stable(ram_rdata))))
        else $error("configuration read data changed during a stall");

    a_cfg_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> (r_cfg_vld != '0))
        else $error("configuration write left no valid entry");
`endif

endmodule
